// ===== design/ppmfe_pkg.sv =====
// shared types and constants for the ppm frame encoder
// no dependencies; imported by every module of the block
package ppmfe_pkg;

   localparam int NUM_CH      = 8;
   localparam int CH_W        = 12;
   localparam int SYNC_W      = 16;
   localparam int TICKS_W     = 8;
   localparam int INTERVAL_W  = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = NUM_CH * CH_W;
   localparam int RSP_TDATA_W = 32;

   localparam int DEFAULT_CHANNEL_RST = 1500;

   // register reset values
   localparam logic [TICKS_W-1:0] TICKS_PER_US_RST   = 8'd5;
   localparam logic [CH_W-1:0]    MIN_CHANNEL_US_RST = 12'd1000;
   localparam logic [CH_W-1:0]    MAX_CHANNEL_US_RST = 12'd2000;
   localparam logic [CH_W-1:0]    GAP_US_RST         = 12'd500;
   localparam logic [SYNC_W-1:0]  FRAME_US_RST       = 16'd20000;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_TICKS_PER_US   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_CHANNEL_US = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_CHANNEL_US = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_GAP_US         = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_US       = 3'd4;

   typedef enum logic [1:0] {
      PH_GAP      = 2'd0,
      PH_CH       = 2'd1,
      PH_SYNC_GAP = 2'd2,
      PH_SYNC     = 2'd3
   } phase_type;

   typedef struct packed {
      logic [TICKS_W-1:0] ticks_per_us;
      logic [CH_W-1:0]    min_channel_us;
      logic [CH_W-1:0]    max_channel_us;
      logic [CH_W-1:0]    gap_us;
      logic [SYNC_W-1:0]  frame_us;
   } cfg_type;

   typedef struct packed {
      logic                       mode;
      logic [NUM_CH-1:0][CH_W-1:0] channel;
   } item_type;

   typedef struct packed {
      logic                  line_level;
      logic [INTERVAL_W-1:0] interval_ticks;
      logic                  frame_end;
   } result_type;

endpackage

// ===== design/ppmfe_csr.sv =====
// configuration register file of the ppm frame encoder
// depends on ppmfe_pkg
module ppmfe_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ppmfe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ppmfe_pkg::CSR_DATA_W-1:0]   csr_data,
   output ppmfe_pkg::cfg_type                 cfg
);
   import ppmfe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_TICKS_PER_US:   cfg_in.ticks_per_us   = csr_data[TICKS_W-1:0];
            REG_MIN_CHANNEL_US: cfg_in.min_channel_us = csr_data[CH_W-1:0];
            REG_MAX_CHANNEL_US: cfg_in.max_channel_us = csr_data[CH_W-1:0];
            REG_GAP_US:         cfg_in.gap_us         = csr_data[CH_W-1:0];
            REG_FRAME_US:       cfg_in.frame_us       = csr_data[SYNC_W-1:0];
            default:            cfg_in = cfg_ff;  // unknown index ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_us   <= TICKS_PER_US_RST;
         cfg_ff.min_channel_us <= MIN_CHANNEL_US_RST;
         cfg_ff.max_channel_us <= MAX_CHANNEL_US_RST;
         cfg_ff.gap_us         <= GAP_US_RST;
         cfg_ff.frame_us       <= FRAME_US_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/ppmfe_core.sv =====
// channel buffers, phase sequencer and interval computation
// depends on ppmfe_pkg
module ppmfe_core #(
   parameter int DEFAULT_CHANNEL = ppmfe_pkg::DEFAULT_CHANNEL_RST
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ppmfe_pkg::cfg_type    cfg,
   input  ppmfe_pkg::item_type   item,
   input  logic                  fire,
   output logic                  has_result,
   output ppmfe_pkg::result_type result
);
   import ppmfe_pkg::*;

   localparam logic [CH_W-1:0] DEF_CH = CH_W'(DEFAULT_CHANNEL);
   localparam int RST_SYNC_INT = int'(FRAME_US_RST) - 9 * int'(GAP_US_RST)
                                 - NUM_CH * DEFAULT_CHANNEL;
   localparam logic [SYNC_W-1:0] RST_SYNC = SYNC_W'(RST_SYNC_INT);
   localparam logic [3:0] NUM_CH_CNT = 4'(NUM_CH);

   logic [NUM_CH-1:0][CH_W-1:0] staging_ff, staging_in;
   logic [1:0][NUM_CH-1:0][CH_W-1:0] buf_ff;
   logic [1:0][SYNC_W-1:0] buf_sync_ff;
   logic write_slot_ff;
   logic [NUM_CH-1:0][CH_W-1:0] active_ff;
   logic [SYNC_W-1:0] active_sync_ff;
   phase_type phase_ff, phase_in;
   logic [3:0] count_ff, count_in;
   logic skip_ff;

   logic [SYNC_W-1:0] ch_sum;
   logic [SYNC_W-1:0] gap9;
   logic [SYNC_W-1:0] sync_new;
   logic [SYNC_W-1:0] width_us;
   logic              level;
   logic              fend;
   logic [3:0]        count_inc;
   logic [SYNC_W+TICKS_W-1:0] product;

   // staging update and sync width of the new set
   always_comb begin
      ch_sum = '0;
      for (int i = 0; i < NUM_CH; i++) begin
         if (item.channel[i] >= cfg.min_channel_us && item.channel[i] <= cfg.max_channel_us)
            staging_in[i] = item.channel[i];
         else
            staging_in[i] = staging_ff[i];
         ch_sum = ch_sum + SYNC_W'(staging_in[i]);
      end
      gap9     = {{(SYNC_W-CH_W-3){1'b0}}, cfg.gap_us, 3'b000} + SYNC_W'(cfg.gap_us);
      sync_new = cfg.frame_us - gap9 - ch_sum;
   end

   assign count_inc  = count_ff + 4'd1;
   assign has_result = !item.mode && !skip_ff;

   // pulse step of this compare event
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      level    = 1'b0;
      fend     = 1'b0;
      width_us = SYNC_W'(cfg.gap_us);
      unique case (phase_ff)
         PH_GAP: begin
            phase_in = PH_CH;
         end
         PH_CH: begin
            level    = 1'b1;
            width_us = SYNC_W'(active_ff[count_ff[2:0]]);
            count_in = count_inc;
            phase_in = (count_inc >= NUM_CH_CNT) ? PH_SYNC_GAP : PH_GAP;
         end
         PH_SYNC_GAP: begin
            phase_in = PH_SYNC;
         end
         PH_SYNC: begin
            level    = 1'b1;
            width_us = active_sync_ff;
            fend     = 1'b1;
            phase_in = PH_GAP;
            count_in = '0;
         end
         default: begin
            phase_in = PH_GAP;
         end
      endcase
   end

   assign product = width_us * cfg.ticks_per_us;

   always_comb begin
      result.line_level     = level;
      result.interval_ticks = product[INTERVAL_W-1:0];
      result.frame_end      = fend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         staging_ff     <= '0;
         buf_ff         <= {(2 * NUM_CH){DEF_CH}};
         buf_sync_ff    <= {2{RST_SYNC}};
         write_slot_ff  <= 1'b0;
         active_ff      <= {NUM_CH{DEF_CH}};
         active_sync_ff <= RST_SYNC;
         phase_ff       <= PH_GAP;
         count_ff       <= '0;
         skip_ff        <= 1'b1;
      end else if (fire) begin
         if (item.mode) begin
            staging_ff                 <= staging_in;
            buf_ff[write_slot_ff]      <= staging_in;
            buf_sync_ff[write_slot_ff] <= sync_new;
            write_slot_ff              <= !write_slot_ff;
         end else if (skip_ff) begin
            skip_ff <= 1'b0;
         end else begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            if (phase_ff == PH_SYNC) begin
               active_ff      <= buf_ff[!write_slot_ff];
               active_sync_ff <= buf_sync_ff[!write_slot_ff];
            end
         end
      end
   end

endmodule

// ===== design/ppm_frame_encoder.sv =====
// top level of the eight-channel ppm frame encoder
// depends on ppmfe_pkg, ppmfe_csr and ppmfe_core
//
// A request with tuser high submits eight channel widths (in microseconds);
// widths inside the min/max limits update the staging set, which is copied
// with its sync width into the write slot of a double buffer. A request with
// tuser low is a timer compare event and yields one response: the pin level
// for the next interval and that interval in timer ticks; tlast marks the
// sync-high step that ends a frame, at which the next frame's widths load
// from the buffer slot not being written. The first compare event after
// reset yields no response, and submits never do. One request is accepted
// every clock cycle unless a response waits on a full output register; each
// response makes a single pass from the input register through the sequencer
// into the output register. Configuration writes are taken at any time but
// should be made only while no request is in flight.
module ppm_frame_encoder #(
   parameter int DEFAULT_CHANNEL = ppmfe_pkg::DEFAULT_CHANNEL_RST
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // channel_0 .. channel_7, 12 bits each, channel_0 lowest
   input  logic [ppmfe_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // mode: 0 compare event, 1 submit
   input  logic                               req_tuser,
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // line_level [0], interval_ticks [24:1], zero pad [31:25]
   output logic [ppmfe_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // frame_end
   output logic                               rsp_tlast,
   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ppmfe_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ppmfe_pkg::CSR_DATA_W-1:0]   csr_data
);
   import ppmfe_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_valid_ff;
   logic       has_result;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_free;
   logic       fire;

   // output register can take a new response this cycle
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   // a request with no response never waits on the output side
   assign fire       = item_valid_ff && (!has_result || rsp_free);
   assign req_tready = !item_valid_ff || fire;

   ppmfe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ppmfe_core #(
      .DEFAULT_CHANNEL (DEFAULT_CHANNEL)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item       (item_ff),
      .fire       (fire),
      .has_result (has_result),
      .result     (result)
   );

   // input register, control part
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   // input register, payload
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.mode    <= req_tuser;
         item_ff.channel <= req_tdata;
      end
   end

   // output register, control part
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // output register, payload
   always_ff @(posedge clock) begin
      if (fire && has_result) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - INTERVAL_W - 1){1'b0}},
                        rsp_ff.interval_ticks, rsp_ff.line_level};
   assign rsp_tlast  = rsp_ff.frame_end;

endmodule

// ===== verif/ppm_frame_encoder_tb.sv =====
// self-checking testbench for ppm_frame_encoder: directed and random requests
// against a cycle-free predictor of the pulse sequence; depends on ppmfe_pkg
`timescale 1ns / 1ps

module ppm_frame_encoder_tb;
   import ppmfe_pkg::*;

   localparam logic MODE_COMPARE     = 1'b0;
   localparam logic MODE_SUBMIT      = 1'b1;
   localparam int   NUM_REGS         = 5;
   localparam int   FIRST_UNUSED_REG = NUM_REGS;
   localparam int   SETTLE_CYCLES    = 4;
   localparam int   RANDOM_ITEMS     = 75;
   localparam int   WATCHDOG_LIMIT   = 5000;  // cycles with no handshake at all

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;
   logic                    req_tuser  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_data   = '0;

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int mismatch_count = 0;

   // predictor copy of the registers
   logic [TICKS_W-1:0] m_ticks;
   logic [CH_W-1:0]    m_min;
   logic [CH_W-1:0]    m_max;
   logic [CH_W-1:0]    m_gap;
   logic [SYNC_W-1:0]  m_frame;

   // predictor copy of the frame state
   logic [NUM_CH-1:0][CH_W-1:0] staged_w;
   logic [NUM_CH-1:0][CH_W-1:0] slot_w [2];
   logic [SYNC_W-1:0]           slot_sync [2];
   logic                        wr_slot;
   logic [NUM_CH-1:0][CH_W-1:0] live_w;
   logic [SYNC_W-1:0]           live_sync;
   phase_type                   step_phase;
   logic [3:0]                  ch_count;
   logic                        first_pending;

   result_type expected_pulses [$];
   result_type pulse_due;

   ppm_frame_encoder #(.DEFAULT_CHANNEL(DEFAULT_CHANNEL_RST)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // sync width: frame minus nine gaps minus the channel sum, wrapping at 16 bits
   function automatic logic [SYNC_W-1:0] sync_width_of(input logic [NUM_CH-1:0][CH_W-1:0] w);
      logic [SYNC_W-1:0] s;
      s = m_frame;
      for (int c = 0; c < NUM_CH; c++)
         s = s - SYNC_W'(m_gap) - SYNC_W'(w[c]);
      return s - SYNC_W'(m_gap);
   endfunction

   task automatic reset_frame_model();
      m_ticks = TICKS_PER_US_RST;
      m_min   = MIN_CHANNEL_US_RST;
      m_max   = MAX_CHANNEL_US_RST;
      m_gap   = GAP_US_RST;
      m_frame = FRAME_US_RST;
      for (int c = 0; c < NUM_CH; c++) begin
         staged_w[c]  = '0;
         slot_w[0][c] = CH_W'(DEFAULT_CHANNEL_RST);
         slot_w[1][c] = CH_W'(DEFAULT_CHANNEL_RST);
         live_w[c]    = CH_W'(DEFAULT_CHANNEL_RST);
      end
      live_sync     = sync_width_of(live_w);
      slot_sync[0]  = live_sync;
      slot_sync[1]  = live_sync;
      wr_slot       = 1'b0;
      step_phase    = PH_GAP;
      ch_count      = '0;
      first_pending = 1'b1;
   endtask

   task automatic apply_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_TICKS_PER_US:   m_ticks = val[TICKS_W-1:0];
         REG_MIN_CHANNEL_US: m_min   = val[CH_W-1:0];
         REG_MAX_CHANNEL_US: m_max   = val[CH_W-1:0];
         REG_GAP_US:         m_gap   = val[CH_W-1:0];
         REG_FRAME_US:       m_frame = val[SYNC_W-1:0];
         default: ;
      endcase
   endtask

   // advance the frame state by one accepted request, queueing the pulse it yields
   task automatic predict_pulse_step(input logic mode, input logic [REQ_TDATA_W-1:0] data);
      result_type        pulse;
      logic [SYNC_W-1:0] width_us;
      logic [CH_W-1:0]   offered;
      if (mode == MODE_SUBMIT) begin
         for (int c = 0; c < NUM_CH; c++) begin
            offered = data[c*CH_W +: CH_W];
            if (offered >= m_min && offered <= m_max)
               staged_w[c] = offered;
         end
         slot_w[wr_slot]    = staged_w;
         slot_sync[wr_slot] = sync_width_of(staged_w);
         wr_slot            = ~wr_slot;
      end else if (first_pending) begin
         first_pending = 1'b0;
      end else begin
         pulse.frame_end = 1'b0;
         case (step_phase)
            PH_GAP: begin
               pulse.line_level = 1'b0;
               width_us         = SYNC_W'(m_gap);
               step_phase       = PH_CH;
            end
            PH_CH: begin
               pulse.line_level = 1'b1;
               width_us         = SYNC_W'(live_w[ch_count[2:0]]);
               ch_count         = ch_count + 4'd1;
               step_phase       = (ch_count >= NUM_CH) ? PH_SYNC_GAP : PH_GAP;
            end
            PH_SYNC_GAP: begin
               pulse.line_level = 1'b0;
               width_us         = SYNC_W'(m_gap);
               step_phase       = PH_SYNC;
            end
            default: begin
               // sync high closes the frame and loads the slot not being written
               pulse.line_level = 1'b1;
               pulse.frame_end  = 1'b1;
               width_us         = live_sync;
               live_w           = slot_w[~wr_slot];
               live_sync        = slot_sync[~wr_slot];
               step_phase       = PH_GAP;
               ch_count         = '0;
            end
         endcase
         pulse.interval_ticks = INTERVAL_W'(width_us) * INTERVAL_W'(m_ticks);
         expected_pulses.push_back(pulse);
      end
   endtask

   // response check first, then prediction, so ordering inside the step is fixed
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pulses.size() == 0) begin
            $error("response with no compare event pending: tdata 0x%h tlast %b",
                   rsp_tdata, rsp_tlast);
            mismatch_count++;
         end else begin
            pulse_due = expected_pulses.pop_front();
            if (rsp_tdata[0] !== pulse_due.line_level) begin
               $error("line_level: expected %0d, got %0d", pulse_due.line_level, rsp_tdata[0]);
               mismatch_count++;
            end
            if (rsp_tdata[INTERVAL_W:1] !== pulse_due.interval_ticks) begin
               $error("interval_ticks: expected %0d, got %0d",
                      pulse_due.interval_ticks, rsp_tdata[INTERVAL_W:1]);
               mismatch_count++;
            end
            if (rsp_tlast !== pulse_due.frame_end) begin
               $error("frame_end: expected %0d, got %0d", pulse_due.frame_end, rsp_tlast);
               mismatch_count++;
            end
            if (rsp_tdata[RSP_TDATA_W-1:INTERVAL_W+1] !== '0) begin
               $error("tdata padding: expected 0, got 0x%h",
                      rsp_tdata[RSP_TDATA_W-1:INTERVAL_W+1]);
               mismatch_count++;
            end
         end
      end
      if (!reset && req_tvalid && req_tready)
         predict_pulse_step(req_tuser, req_tdata);
      if (!reset && csr_valid && csr_ready)
         apply_register(csr_index, csr_data);
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // one request; valid stays high into the next call unless the sender idles
   task automatic send_request(input logic mode, input logic [REQ_TDATA_W-1:0] data);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending until every queued pulse is back; sampled at negedge to
   // see the queue after the posedge updates
   task automatic drain_responses(input int settle_cycles);
      req_tvalid <= 1'b0;
      do @(negedge clock); while (expected_pulses.size() != 0);
      repeat (settle_cycles + 1) @(posedge clock);
   endtask

   // all five registers plus one unused index; junk above each field must be dropped
   task automatic set_config(input logic [TICKS_W-1:0] ticks, input logic [CH_W-1:0] lo,
                             input logic [CH_W-1:0] hi, input logic [CH_W-1:0] gap,
                             input logic [SYNC_W-1:0] frame);
      logic [CSR_INDEX_W-1:0] idx [NUM_REGS+1];
      logic [CSR_DATA_W-1:0]  val [NUM_REGS+1];
      for (int i = 0; i <= NUM_REGS; i++)
         val[i] = CSR_DATA_W'($urandom);
      idx[0] = REG_TICKS_PER_US;   val[0][TICKS_W-1:0] = ticks;
      idx[1] = REG_MIN_CHANNEL_US; val[1][CH_W-1:0]    = lo;
      idx[2] = REG_MAX_CHANNEL_US; val[2][CH_W-1:0]    = hi;
      idx[3] = REG_GAP_US;         val[3][CH_W-1:0]    = gap;
      idx[4] = REG_FRAME_US;       val[4]              = frame;
      idx[5] = CSR_INDEX_W'($urandom_range(2**CSR_INDEX_W - 1, FIRST_UNUSED_REG));
      for (int i = 0; i <= NUM_REGS; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // mostly compare events with noise in tdata; submits favor in-range widths
   task automatic run_random(input int count);
      logic [REQ_TDATA_W-1:0] data;
      logic                   mode;
      logic [CH_W-1:0]        w;
      for (int n = 0; n < count; n++) begin
         mode = ($urandom_range(99) < 15) ? MODE_SUBMIT : MODE_COMPARE;
         data = REQ_TDATA_W'({$urandom(), $urandom(), $urandom()});
         if (mode == MODE_SUBMIT) begin
            for (int c = 0; c < NUM_CH; c++) begin
               case ($urandom_range(9))
                  0:       w = m_min;
                  1:       w = m_max;
                  2:       w = m_min - 1'b1;
                  3:       w = m_max + 1'b1;
                  4, 5:    w = CH_W'($urandom);
                  default: w = CH_W'($urandom_range(m_max, m_min));
               endcase
               data[c*CH_W +: CH_W] = w;
            end
         end
         send_request(mode, data);
         // occasional full pause until the pipe is empty
         if ($urandom_range(59) == 0)
            drain_responses(0);
      end
   endtask

   // reset values: first compare swallowed, boundary widths, a full default frame
   task automatic test_reset_frame();
      logic [REQ_TDATA_W-1:0] data;
      send_request(MODE_COMPARE, '1);
      data = {12'd1234, CH_W'(DEFAULT_CHANNEL_RST), {CH_W{1'b1}}, {CH_W{1'b0}},
              MAX_CHANNEL_US_RST + 1'b1, MIN_CHANNEL_US_RST - 1'b1,
              MAX_CHANNEL_US_RST, MIN_CHANNEL_US_RST};
      send_request(MODE_SUBMIT, data);
      for (int c = 0; c < NUM_CH; c++)
         data[c*CH_W +: CH_W] = CH_W'($urandom_range(MAX_CHANNEL_US_RST, MIN_CHANNEL_US_RST));
      send_request(MODE_SUBMIT, data);
      // gap/channel pairs for all channels, then sync gap and sync
      repeat (2*NUM_CH + 2)
         send_request(MODE_COMPARE, REQ_TDATA_W'({$urandom(), $urandom(), $urandom()}));
   endtask

   // widest limits, longest gap, zero frame so the sync width wraps
   task automatic test_extreme_limits();
      drain_responses(SETTLE_CYCLES);
      set_config({TICKS_W{1'b1}}, '0, {CH_W{1'b1}}, {CH_W{1'b1}}, '0);
      run_random(RANDOM_ITEMS);
   endtask

   // min above max rejects every width; staging set must stay as it was
   task automatic test_min_above_max();
      drain_responses(SETTLE_CYCLES);
      set_config(TICKS_W'(1), {CH_W{1'b1}}, '0, '0, {SYNC_W{1'b1}});
      run_random(RANDOM_ITEMS);
   endtask

   task automatic test_zero_ticks();
      drain_responses(SETTLE_CYCLES);
      set_config('0, CH_W'($urandom_range(800)), CH_W'($urandom_range(4095, 2500)),
                 CH_W'($urandom), SYNC_W'($urandom));
      run_random(RANDOM_ITEMS);
   endtask

   task automatic test_random_settings();
      logic [CH_W-1:0] lo;
      lo = CH_W'($urandom_range(2000));
      drain_responses(SETTLE_CYCLES);
      set_config(TICKS_W'($urandom_range(255, 1)), lo, CH_W'($urandom_range(4095, lo)),
                 CH_W'($urandom_range(1000)), SYNC_W'($urandom));
      run_random(RANDOM_ITEMS);
   endtask

   initial begin
      reset_frame_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // slow sender, slow receiver
      send_idle_pct = 35;
      recv_idle_pct = 87;
      test_reset_frame();
      test_extreme_limits();

      send_idle_pct = 87;
      recv_idle_pct = 35;
      test_min_above_max();
      test_zero_ticks();

      // back to back
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_settings();
      test_random_settings();

      drain_responses(SETTLE_CYCLES);
      if (mismatch_count == 0)
         $display("PASS ppm_frame_encoder");
      else
         $display("FAIL ppm_frame_encoder");
      $finish;
   end

   // ends the run when no handshake of any kind happens for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAIL ppm_frame_encoder");
      $finish;
   end

endmodule
